### src/rfe_pkg.sv
// shared types, constants and helpers of the r-function shape evaluator
package rfe_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // operand widths
    localparam int MAG_W  = 33;   // magnitude of a coordinate offset or a divisor
    localparam int TERM_W = 35;   // squared ratio term, capped at 2^34
    localparam int QBITS  = 32;   // quotient bits of the ratio divider
    localparam int SIZE_W = 31;   // size registers
    localparam int MODE_W = 3;
    localparam int IDX_W  = 3;

    localparam logic [63:0] TERM_CAP = 64'h0000_0004_0000_0000;

    // pipeline depths of the arithmetic units
    localparam int RATIO_LAT = QBITS + 3;
    localparam int JOIN_LAT  = QBITS + 3;

    // shape modes
    localparam logic [MODE_W-1:0] MODE_CIRCLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ELLIPSE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RECT      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROUNDED   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SPHERE    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ELLIPSOID = 3'd5;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SHAPE_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_A        = 3'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_B        = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_C        = 3'd3;
    localparam logic [IDX_W-1:0] REG_CORNER_RADIUS = 3'd4;

    // r-function join kind
    localparam logic JOIN_CON = 1'b0;
    localparam logic JOIN_DIS = 1'b1;

    // 32-bit value with its running saturation flag
    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sval_t;

    function automatic sval_t sat32(input logic signed [39:0] v);
        sval_t r;
        if (v > 40'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag34(input logic signed [33:0] v);
        logic [33:0] n;
        n = v[33] ? (~v + 34'd1) : v;
        return n[MAG_W-1:0];
    endfunction

endpackage

### src/rfe_delay.sv
// payload delay line advancing with the pipeline enable
module rfe_delay #(
    parameter int W     = 33,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] sr_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[DEPTH-1];
endmodule

### src/rfe_ratio.sv
// pipelined squared ratio term: (v/d)^2, or (2v/d)^2 with e set, one quotient bit per stage
module rfe_ratio #(
    parameter int FRAC_BITS = rfe_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rfe_pkg::MAG_W-1:0]   v_mag,
    input  logic [rfe_pkg::MAG_W-1:0]   d_mag,
    input  logic                        e,
    output logic [rfe_pkg::TERM_W-1:0]  term
);
    import rfe_pkg::*;

    localparam int NUMW = MAG_W + FRAC_BITS + 1;
    localparam int RW   = (NUMW > MAG_W + QBITS) ? NUMW : MAG_W + QBITS;

    logic [RW-1:0]     nmr;
    logic [RW-1:0]     dsh;
    logic [RW-1:0]     rem_reg  [0:QBITS-1];
    logic [MAG_W-1:0]  d_reg    [0:QBITS-1];
    logic [QBITS-1:0]  q_reg    [1:QBITS];
    logic              cap_reg  [0:QBITS+1];
    logic              zero_reg [0:QBITS+1];
    logic [63:0]       sq_reg;
    logic [63:0]       sh;
    logic [TERM_W-1:0] term_reg;

    always_comb begin
        nmr = RW'(v_mag) << FRAC_BITS;
        if (e) begin
            nmr = nmr << 1;
        end
        dsh = RW'(d_mag) << QBITS;
    end

    // entry: overflow and zero-divisor detection
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= nmr;
            d_reg[0]    <= d_mag;
            zero_reg[0] <= (d_mag == '0) && (v_mag == '0);
            cap_reg[0]  <= (d_mag == '0) ? (v_mag != '0) : (nmr >= dsh);
        end
    end

    // restoring division, msb first
    for (genvar k = 0; k < QBITS; k++) begin : g_div
        localparam int BIT = QBITS - 1 - k;
        logic [RW-1:0]    sub;
        logic             ge;
        logic [QBITS-1:0] qprev;

        assign sub = RW'(d_reg[k]) << BIT;
        assign ge  = rem_reg[k] >= sub;
        if (k == 0) begin : g_q0
            assign qprev = '0;
        end else begin : g_qn
            assign qprev = q_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]    <= {qprev[QBITS-2:0], ge};
                cap_reg[k+1]  <= cap_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end

        if (k < QBITS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? (rem_reg[k] - sub) : rem_reg[k];
                    d_reg[k+1]   <= d_reg[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg            <= 64'(q_reg[QBITS]) * 64'(q_reg[QBITS]);
            cap_reg[QBITS+1]  <= cap_reg[QBITS];
            zero_reg[QBITS+1] <= zero_reg[QBITS];
        end
    end

    assign sh = sq_reg >> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[QBITS+1]) begin
                term_reg <= '0;
            end else if (cap_reg[QBITS+1] || (sh > TERM_CAP)) begin
                term_reg <= TERM_CAP[TERM_W-1:0];
            end else begin
                term_reg <= sh[TERM_W-1:0];
            end
        end
    end

    assign term = term_reg;
endmodule

### src/rfe_isqrt.sv
// pipelined integer square root of a 64-bit value, one root bit per stage
module rfe_isqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [63:0]                n,
    output logic [rfe_pkg::QBITS-1:0]  root
);
    import rfe_pkg::*;

    logic [63:0] rem_reg [1:QBITS-1];
    logic [63:0] res_reg [1:QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        localparam int BITPOS = 2 * (QBITS - 1 - k);
        logic [63:0] rin;
        logic [63:0] resin;
        logic [64:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign rin   = n;
            assign resin = '0;
        end else begin : g_next
            assign rin   = rem_reg[k];
            assign resin = res_reg[k];
        end

        assign trial = {1'b0, resin} + (65'd1 << BITPOS);
        assign ge    = {1'b0, rin} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[k+1] <= ge ? ((resin >> 1) + (64'd1 << BITPOS)) : (resin >> 1);
            end
        end

        if (k < QBITS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? (rin - trial[63:0]) : rin;
                end
            end
        end
    end

    assign root = res_reg[QBITS][QBITS-1:0];
endmodule

### src/rfe_join.sv
// pipelined r-conjunction / r-disjunction u + v -/+ sqrt(u^2 + v^2)
module rfe_join (
    input  logic            aclk,
    input  logic            en,
    input  logic            disj,
    input  rfe_pkg::sval_t  u,
    input  rfe_pkg::sval_t  v,
    output rfe_pkg::sval_t  r
);
    import rfe_pkg::*;

    logic [31:0]       au;
    logic [31:0]       av;
    logic [63:0]       sqa_reg;
    logic [63:0]       sqb_reg;
    logic [63:0]       n_reg;
    logic [QBITS-1:0]  root;
    sval_t             ud;
    sval_t             vd;
    logic signed [39:0] sum;
    sval_t             sr;
    sval_t             r_reg;

    assign au = u.val[31] ? (~u.val + 32'd1) : u.val;
    assign av = v.val[31] ? (~v.val + 32'd1) : v.val;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqa_reg <= 64'(au) * 64'(au);
            sqb_reg <= 64'(av) * 64'(av);
            n_reg   <= sqa_reg + sqb_reg;
        end
    end

    rfe_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .n    (n_reg),
        .root (root)
    );

    // operands wait for the root
    rfe_delay #(.W(2 * $bits(sval_t)), .DEPTH(JOIN_LAT - 1)) u_opd (
        .aclk (aclk),
        .en   (en),
        .din  ({u, v}),
        .dout ({ud, vd})
    );

    always_comb begin
        if (disj) begin
            sum = 40'(ud.val) + 40'(vd.val) + $signed({8'b0, root});
        end else begin
            sum = 40'(ud.val) + 40'(vd.val) - $signed({8'b0, root});
        end
        sr     = sat32(sum);
        sr.sat = sr.sat | ud.sat | vd.sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= sr;
        end
    end

    assign r = r_reg;
endmodule

### src/implicit_shape_rfunction_eval_top.sv
// top level of the r-function implicit shape evaluator
//
// Evaluates the implicit function of the configured shape (circle, ellipse,
// rectangle, rounded rectangle, sphere, ellipsoid) at one point per
// transfer, in signed fixed point with FRAC_BITS fractional bits. A new
// point is taken every cycle unless the output stalls; each point passes
// through the operand register, one 35-stage ratio divider
// column, the primitive register, four chained 35-stage square-root joins
// (the depth of the rounded rectangle path, which all shapes share so the
// results stay in order) and the output register; the operand register
// loads on the taking edge itself.
// The whole pipeline moves on one enable that is high whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// The user must write registers through the plain write port only while no point
// is in flight, unenforced by the block; field_value on m_tdata, saturated on m_tuser.
module implicit_shape_rfunction_eval_top #(
    parameter int FRAC_BITS = rfe_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input points
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [95:0]                 s_tdata,   // px [31:0], py [63:32], pz [95:64]
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // field_value [31:0]
    output logic                        m_tuser,   // saturated [0]
    // register writes
    input  logic                        cfg_wr_en,
    input  logic [rfe_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rfe_pkg::SIZE_W-1:0]  cfg_wdata
);
    import rfe_pkg::*;

    localparam int NLANE   = 12;
    localparam int VLD_LEN = 1 + RATIO_LAT + 1 + 4 * JOIN_LAT;
    localparam logic signed [39:0] ONE_Q = 40'sd1 <<< FRAC_BITS;
    localparam logic [SIZE_W-1:0]  ONE_S = SIZE_W'(1) << FRAC_BITS;

    // configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [SIZE_W-1:0] size_a_reg;
    logic [SIZE_W-1:0] size_b_reg;
    logic [SIZE_W-1:0] size_c_reg;
    logic [SIZE_W-1:0] corner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_CIRCLE;
            size_a_reg <= ONE_S;
            size_b_reg <= ONE_S;
            size_c_reg <= ONE_S;
            corner_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SHAPE_MODE:    mode_reg   <= cfg_wdata[MODE_W-1:0];
                REG_SIZE_A:        size_a_reg <= cfg_wdata;
                REG_SIZE_B:        size_b_reg <= cfg_wdata;
                REG_SIZE_C:        size_c_reg <= cfg_wdata;
                REG_CORNER_RADIUS: corner_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advance: output slot free or being drained
    logic en;
    logic m_tvalid_reg;
    logic [VLD_LEN-1:0] vld_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[VLD_LEN-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[VLD_LEN-1];
        end
    end

    // operand setup for the twelve ratio lanes
    // lanes 0-3: band terms, lanes 4-11: circle term pairs or quadric terms
    logic signed [33:0] xs, ys, zs, cx, cy, xmc, xpc, ymc, ypc, wm2r, hm2r;
    logic [MAG_W-1:0]   ma, mb, mc, mr;
    logic [MAG_W-1:0]   lv     [0:NLANE-1];
    logic [MAG_W-1:0]   ld     [0:NLANE-1];
    logic               le     [0:NLANE-1];
    logic [MAG_W-1:0]   lv_reg [0:NLANE-1];
    logic [MAG_W-1:0]   ld_reg [0:NLANE-1];
    logic               le_reg [0:NLANE-1];

    always_comb begin
        xs   = 34'($signed(s_tdata[31:0]));
        ys   = 34'($signed(s_tdata[63:32]));
        zs   = 34'($signed(s_tdata[95:64]));
        cx   = $signed({4'b0, size_a_reg[SIZE_W-1:1]}) - $signed({3'b0, corner_reg});
        cy   = $signed({4'b0, size_b_reg[SIZE_W-1:1]}) - $signed({3'b0, corner_reg});
        xmc  = xs - cx;
        xpc  = xs + cx;
        ymc  = ys - cy;
        ypc  = ys + cy;
        wm2r = $signed({3'b0, size_a_reg}) - $signed({2'b0, corner_reg, 1'b0});
        hm2r = $signed({3'b0, size_b_reg}) - $signed({2'b0, corner_reg, 1'b0});
        ma   = {2'b0, size_a_reg};
        mb   = {2'b0, size_b_reg};
        mc   = {2'b0, size_c_reg};
        mr   = {2'b0, corner_reg};
        for (int k = 0; k < NLANE; k++) begin
            lv[k] = '0;
            ld[k] = MAG_W'(1);
            le[k] = 1'b0;
        end
        case (mode_reg)
            MODE_CIRCLE: begin
                lv[4] = mag34(xs); ld[4] = ma;
                lv[5] = mag34(ys); ld[5] = ma;
            end
            MODE_ELLIPSE: begin
                lv[4] = mag34(xs); ld[4] = ma;
                lv[5] = mag34(ys); ld[5] = mb;
            end
            MODE_SPHERE: begin
                lv[4] = mag34(xs); ld[4] = ma;
                lv[5] = mag34(ys); ld[5] = ma;
                lv[6] = mag34(zs); ld[6] = ma;
            end
            MODE_ELLIPSOID: begin
                lv[4] = mag34(xs); ld[4] = ma;
                lv[5] = mag34(ys); ld[5] = mb;
                lv[6] = mag34(zs); ld[6] = mc;
            end
            MODE_RECT: begin
                lv[0] = mag34(xs); ld[0] = ma; le[0] = 1'b1;
                lv[1] = mag34(ys); ld[1] = mb; le[1] = 1'b1;
            end
            MODE_ROUNDED: begin
                // narrow-width and narrow-height rectangles
                lv[0] = mag34(xs); ld[0] = mag34(wm2r); le[0] = 1'b1;
                lv[1] = mag34(ys); ld[1] = mb;          le[1] = 1'b1;
                lv[2] = mag34(xs); ld[2] = ma;          le[2] = 1'b1;
                lv[3] = mag34(ys); ld[3] = mag34(hm2r); le[3] = 1'b1;
                // four corner circles
                lv[4]  = mag34(xmc); ld[4]  = mr;
                lv[5]  = mag34(ymc); ld[5]  = mr;
                lv[6]  = mag34(xpc); ld[6]  = mr;
                lv[7]  = mag34(ymc); ld[7]  = mr;
                lv[8]  = mag34(xpc); ld[8]  = mr;
                lv[9]  = mag34(ypc); ld[9]  = mr;
                lv[10] = mag34(xmc); ld[10] = mr;
                lv[11] = mag34(ypc); ld[11] = mr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NLANE; k++) begin
                lv_reg[k] <= lv[k];
                ld_reg[k] <= ld[k];
                le_reg[k] <= le[k];
            end
        end
    end

    // ratio term column
    logic [TERM_W-1:0] term [0:NLANE-1];

    for (genvar k = 0; k < NLANE; k++) begin : g_lane
        rfe_ratio #(.FRAC_BITS(FRAC_BITS)) u_ratio (
            .aclk  (aclk),
            .en    (en),
            .v_mag (lv_reg[k]),
            .d_mag (ld_reg[k]),
            .e     (le_reg[k]),
            .term  (term[k])
        );
    end

    // primitives: bands, corner circles, quadric
    logic signed [39:0] ts [0:NLANE-1];
    sval_t band_reg [0:3];
    sval_t circ_reg [0:3];
    sval_t quad_reg;

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            ts[k] = $signed({5'b0, term[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                band_reg[k] <= sat32(ONE_Q - ts[k]);
                circ_reg[k] <= sat32(ONE_Q - ts[4 + 2 * k] - ts[5 + 2 * k]);
            end
            quad_reg <= sat32(ONE_Q - ts[4] - ts[5] - ts[6]);
        end
    end

    // join tree
    sval_t j1a, j1b, j1c, j2a, j2b, j3, j4;
    sval_t c2_d, c3_d, j2a_d, j1a_d, quad_d;

    rfe_join u_j1a (.aclk(aclk), .en(en), .disj(JOIN_CON),
                    .u(band_reg[0]), .v(band_reg[1]), .r(j1a));
    rfe_join u_j1b (.aclk(aclk), .en(en), .disj(JOIN_CON),
                    .u(band_reg[2]), .v(band_reg[3]), .r(j1b));
    rfe_join u_j1c (.aclk(aclk), .en(en), .disj(JOIN_DIS),
                    .u(circ_reg[0]), .v(circ_reg[1]), .r(j1c));

    rfe_delay #(.W($bits(sval_t)), .DEPTH(JOIN_LAT)) u_c2_d (
        .aclk(aclk), .en(en), .din(circ_reg[2]), .dout(c2_d));
    rfe_delay #(.W($bits(sval_t)), .DEPTH(2 * JOIN_LAT)) u_c3_d (
        .aclk(aclk), .en(en), .din(circ_reg[3]), .dout(c3_d));

    rfe_join u_j2a (.aclk(aclk), .en(en), .disj(JOIN_DIS),
                    .u(j1a), .v(j1b), .r(j2a));
    rfe_join u_j2b (.aclk(aclk), .en(en), .disj(JOIN_DIS),
                    .u(j1c), .v(c2_d), .r(j2b));

    rfe_join u_j3 (.aclk(aclk), .en(en), .disj(JOIN_DIS),
                   .u(j2b), .v(c3_d), .r(j3));
    rfe_delay #(.W($bits(sval_t)), .DEPTH(JOIN_LAT)) u_j2a_d (
        .aclk(aclk), .en(en), .din(j2a), .dout(j2a_d));

    rfe_join u_j4 (.aclk(aclk), .en(en), .disj(JOIN_DIS),
                   .u(j2a_d), .v(j3), .r(j4));

    // plain rectangle and quadric results wait for the deepest path
    rfe_delay #(.W($bits(sval_t)), .DEPTH(3 * JOIN_LAT)) u_j1a_d (
        .aclk(aclk), .en(en), .din(j1a), .dout(j1a_d));
    rfe_delay #(.W($bits(sval_t)), .DEPTH(4 * JOIN_LAT)) u_quad_d (
        .aclk(aclk), .en(en), .din(quad_reg), .dout(quad_d));

    // output register
    sval_t res;
    sval_t res_reg;

    always_comb begin
        if (mode_reg inside {MODE_CIRCLE, MODE_ELLIPSE, MODE_SPHERE, MODE_ELLIPSOID}) begin
            res = quad_d;
        end else if (mode_reg == MODE_RECT) begin
            res = j1a_d;
        end else if (mode_reg == MODE_ROUNDED) begin
            res = j4;
        end else begin
            res = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg.val;
    assign m_tuser  = res_reg.sat;
endmodule

### sim/tb_implicit_shape_rfunction_eval_top.sv
// testbench of the r-function implicit shape evaluator: directed table, then random points
`timescale 1ns / 1ps

module tb_implicit_shape_rfunction_eval_top;
    import rfe_pkg::*;

    // index past the last register, writes there must be ignored
    localparam logic [IDX_W-1:0] REG_NONE = 3'd5;
    localparam logic [2:0] MODE_SPARE = 3'd6;
    localparam longint ONE_Q = 64'sd65536;
    localparam longint CAP = 64'sd17179869184;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 250;
    localparam int RAND_PHASES = 24;
    localparam int PHASE_POINTS = 40;

    typedef struct {
        logic signed [31:0] val;
        logic               sat;
    } shape_res_t;

    // one directed row: shape setup (applied when new_cfg), point, typed answer if known
    typedef struct {
        bit          new_cfg;
        logic [30:0] mode_word;
        logic [30:0] a, b, c, r;
        logic [31:0] px, py, pz;
        bit          known;
        logic [31:0] val;
        logic        sat;
    } point_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic [2:0]  cur_mode = MODE_CIRCLE;
    logic [30:0] cur_a = 31'd65536, cur_b = 31'd65536, cur_c = 31'd65536, cur_r = '0;

    shape_res_t field_q[$];
    int n_sent = 0;
    int n_bad = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    implicit_shape_rfunction_eval_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // ---------------- predictor ----------------

    function automatic longint unsigned magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clip32(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // squared ratio (v/d)^2, times 4 when dbl is set; capped at 2^34
    function automatic longint ratio_term(longint v, longint d, bit dbl);
        longint unsigned av, ad, t, sq;
        av = magn(v);
        ad = magn(d);
        if (ad == 0) return (av == 0) ? 0 : CAP;
        t = (av << (16 + dbl)) / ad;
        if (t >= 64'h1_0000_0000) return CAP;
        sq = (t * t) >> 16;
        if (sq > CAP) return CAP;
        return longint'(sq);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // r-conjunction or r-disjunction of two values already in 32-bit range
    function automatic longint r_join(longint u, longint v, bit dis, inout bit flag);
        longint unsigned au, av;
        longint s;
        au = magn(u);
        av = magn(v);
        s = longint'(root_floor(au * au + av * av));
        return clip32(dis ? u + v + s : u + v - s, flag);
    endfunction

    function automatic longint rect_val(longint x, longint y, longint w, longint h,
                                        inout bit flag);
        longint bx, by;
        bx = clip32(ONE_Q - ratio_term(x, w, 1'b1), flag);
        by = clip32(ONE_Q - ratio_term(y, h, 1'b1), flag);
        return r_join(bx, by, JOIN_CON, flag);
    endfunction

    function automatic longint quad_val(longint x, longint a, longint y, longint b,
                                        longint z, longint c, inout bit flag);
        return clip32(ONE_Q - ratio_term(x, a, 1'b0) - ratio_term(y, b, 1'b0)
                      - ratio_term(z, c, 1'b0), flag);
    endfunction

    function automatic longint rounded_val(longint x, longint y, inout bit flag);
        longint w, h, r, cx, cy, r1, r2, rr, cc;
        w = cur_a;
        h = cur_b;
        r = cur_r;
        cx = (w >>> 1) - r;
        cy = (h >>> 1) - r;
        r1 = rect_val(x, y, w - 2 * r, h, flag);
        r2 = rect_val(x, y, w, h - 2 * r, flag);
        rr = r_join(r1, r2, JOIN_DIS, flag);
        cc = r_join(quad_val(x - cx, r, y - cy, r, 0, 1, flag),
                    quad_val(x + cx, r, y - cy, r, 0, 1, flag), JOIN_DIS, flag);
        cc = r_join(cc, quad_val(x + cx, r, y + cy, r, 0, 1, flag), JOIN_DIS, flag);
        cc = r_join(cc, quad_val(x - cx, r, y + cy, r, 0, 1, flag), JOIN_DIS, flag);
        return r_join(rr, cc, JOIN_DIS, flag);
    endfunction

    function automatic shape_res_t shape_field(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz);
        longint x, y, z, a, b, c, v;
        bit flag;
        shape_res_t res;
        x = longint'($signed(px));
        y = longint'($signed(py));
        z = longint'($signed(pz));
        a = cur_a;
        b = cur_b;
        c = cur_c;
        flag = 1'b0;
        case (cur_mode)
            MODE_CIRCLE:    v = quad_val(x, a, y, a, 0, 1, flag);
            MODE_ELLIPSE:   v = quad_val(x, a, y, b, 0, 1, flag);
            MODE_RECT:      v = rect_val(x, y, a, b, flag);
            MODE_ROUNDED:   v = rounded_val(x, y, flag);
            MODE_SPHERE:    v = quad_val(x, a, y, a, z, a, flag);
            MODE_ELLIPSOID: v = quad_val(x, a, y, b, z, c, flag);
            default:        v = 0;
        endcase
        res.val = v[31:0];
        res.sat = flag;
        return res;
    endfunction

    // ---------------- idling ----------------

    function automatic int sender_idle_pct();
        if (n_sent < 317) return 19;
        if (n_sent < 634) return 59;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_sent < 317) return 59;
        if (n_sent < 634) return 19;
        return 0;
    endfunction

    // ---------------- drivers ----------------

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [30:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SHAPE_MODE:    cur_mode = data[2:0];
            REG_SIZE_A:        cur_a = data;
            REG_SIZE_B:        cur_b = data;
            REG_SIZE_C:        cur_c = data;
            REG_CORNER_RADIUS: cur_r = data;
            default: ;
        endcase
    endtask

    // reprogram only once the pipeline has drained
    task automatic set_shape(logic [30:0] mode_word, logic [30:0] a, logic [30:0] b,
                             logic [30:0] c, logic [30:0] r);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (field_q.size() != 0) @(negedge aclk);
        write_reg(REG_SHAPE_MODE, mode_word);
        write_reg(REG_SIZE_A, a);
        write_reg(REG_SIZE_B, b);
        write_reg(REG_SIZE_C, c);
        write_reg(REG_CORNER_RADIUS, r);
        write_reg(REG_NONE, 31'($urandom()));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one point transfer; typed answer replaces the prediction when known
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              bit known, shape_res_t typed);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px};
        do @(posedge aclk); while (!s_tready);
        field_q.push_back(known ? typed : shape_field(px, py, pz));
        n_sent++;
    endtask

    function automatic logic [30:0] rand_size(bit allow_zero);
        case ($urandom_range(0, 9))
            0:       return 31'h7fffffff;
            1:       return allow_zero ? 31'd0 : 31'd1;
            2:       return 31'($urandom());
            default: return 31'($urandom_range(1, 32'h0008_0000));
        endcase
    endfunction

    // mostly near the shape, sometimes anywhere
    function automatic logic [31:0] rand_coord(logic [30:0] span);
        longint m;
        if ($urandom_range(0, 9) < 3) return $urandom();
        m = $urandom_range(0, 32'(span) + 32'(span >> 1));
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        return $urandom_range(0, 1) ? 32'(-m) : 32'(m);
    endfunction

    // ---------------- receiver and checker ----------------

    initial begin
        forever begin
            @(negedge aclk);
            m_tready <= aresetn && ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (field_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %h sat %b", m_tdata, m_tuser);
            end else begin
                if (m_tdata !== field_q[0].val || m_tuser !== field_q[0].sat) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected %h sat %b, got %h sat %b",
                                 field_q[0].val, field_q[0].sat, m_tdata, m_tuser);
                end
                void'(field_q.pop_front());
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    point_row_t rows[] = '{
        // reset shape: unit circle, center and far corner
        '{0, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, 32'h0001_0000, 0},
        '{0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h0, 32'h0, 1, 32'h8000_0000, 1},
        '{0, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'hffffffff, 1, 32'h8000_0000, 1},
        // high bits of the mode word dropped, zero radius
        '{1, 31'h7ffffff8, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, 32'h0001_0000, 0},
        '{0, 0, 0, 0, 0, 0, 32'h1, 32'h0, 32'h0, 1, 32'h8000_0000, 1},
        '{1, MODE_CIRCLE, 31'h7fffffff, 1, 1, 0, 32'h0, 32'h0, 32'h0, 1, 32'h0001_0000, 0},
        '{1, MODE_ELLIPSE, 31'h20000, 31'h8000, 1, 0, 32'h10000, 32'h4000, 32'h0, 0, 0, 0},
        // unit rectangle center: 2 - sqrt(2)
        '{1, MODE_RECT, 31'h10000, 31'h10000, 1, 0, 32'h0, 32'h0, 32'h0, 1, 32'd38391, 0},
        '{1, MODE_RECT, 31'h7fffffff, 31'h7fffffff, 1, 0, 32'h7fffffff, 32'h80000000, 32'h0,
          0, 0, 0},
        '{1, MODE_ROUNDED, 31'h40000, 31'h20000, 1, 31'h8000, 32'h0, 32'h0, 32'h0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 32'h1c000, 32'hffff4000, 32'h0, 0, 0, 0},
        // no rounding radius, then corner radius wider than half the width
        '{1, MODE_ROUNDED, 31'h40000, 31'h20000, 1, 0, 32'h8000, 32'h8000, 32'h0, 0, 0, 0},
        '{1, MODE_ROUNDED, 31'h40000, 31'h60000, 1, 31'h30000, 32'h8000, 32'h0, 32'h0, 0, 0, 0},
        '{1, MODE_ROUNDED, 31'h40000, 31'h20000, 1, 31'h10000, 32'h0, 32'h0, 32'h0, 0, 0, 0},
        '{1, MODE_SPHERE, 31'h10000, 1, 1, 0, 32'h0, 32'h0, 32'h7fffffff, 1, 32'h8000_0000, 1},
        '{0, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, 32'h0001_0000, 0},
        '{1, MODE_ELLIPSOID, 31'h10000, 31'h20000, 31'h30000, 0, 32'h8000, 32'hffff0000,
          32'h18000, 0, 0, 0},
        // zero third axis with z on the plane
        '{1, MODE_ELLIPSOID, 31'h10000, 31'h10000, 0, 0, 32'h4000, 32'h4000, 32'h0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 32'h4000, 32'h4000, 32'h1, 1, 32'h8000_0000, 1},
        // spare modes give zero
        '{1, MODE_SPARE, 1, 1, 1, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 32'h0, 0},
        '{1, 31'd7, 0, 0, 0, 0, 32'h80000000, 32'h1, 32'h0, 1, 32'h0, 0}
    };

    initial begin
        shape_res_t typed;
        logic [30:0] a, b, c, r, span;
        logic [2:0] mode;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].new_cfg)
                set_shape(rows[i].mode_word, rows[i].a, rows[i].b, rows[i].c, rows[i].r);
            typed.val = rows[i].val;
            typed.sat = rows[i].sat;
            send_point(rows[i].px, rows[i].py, rows[i].pz, rows[i].known, typed);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            // shapes cycle so each gets several phases, spare modes now and then
            mode = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(6, 7)) : 3'(p % 6);
            a = rand_size(1'b0);
            b = rand_size(1'b0);
            c = rand_size(1'b0);
            if ($urandom_range(0, 9) == 0) a = rand_size(1'b1);
            r = (a < b ? a : b) >> $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0) r = rand_size(1'b1);
            set_shape({28'($urandom_range(0, 32'h0fff_ffff)), mode}, a, b, c, r);
            span = (a > b) ? a : b;
            if (c > span) span = c;
            for (int k = 0; k < PHASE_POINTS; k++)
                send_point(rand_coord(span), rand_coord(span), rand_coord(span), 1'b0, typed);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (field_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_bad == 0 && field_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
